[hw/rtl/dpbp_pkg.sv]
// ============================================================================
// dpbp_pkg: shared types and constants for depth pixel back-projection
// Pixel and point payloads, configuration layout, width helper functions.
// ============================================================================
package dpbp_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COL_W          = 12;
    localparam int DEPTH_W        = 16;
    localparam int COLOR_W        = 8;
    localparam int COEF_W         = 32;
    localparam int RECIP_W        = 32;
    localparam int DQ_W           = 32;   // metric depth, unsigned Q16.16
    localparam int PNT_W          = 32;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [RECIP_W-1:0] RECIP_RESET = 32'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0,
        CFG_ROW1,
        CFG_ROW2,
        CFG_COL2,
        CFG_COL2_TX,
        CFG_TRANS_YZ,
        CFG_RECIP
    } t_cfg_idx;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [COL_W-1:0]   row;
        logic [DEPTH_W-1:0] depth_raw;
        logic [COLOR_W-1:0] blue_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] red_in;
    } t_pix;

    typedef struct packed {
        logic signed [PNT_W-1:0] point_x;
        logic signed [PNT_W-1:0] point_y;
        logic signed [PNT_W-1:0] point_z;
        logic [COLOR_W-1:0]      red_out;
        logic [COLOR_W-1:0]      green_out;
        logic [COLOR_W-1:0]      blue_out;
    } t_pnt;

    // a[row][col] signed Q3.28, t[axis] signed Q16.16, recip unsigned Q0.32
    typedef struct packed {
        logic [2:0][2:0][COEF_W-1:0] a;
        logic [2:0][PNT_W-1:0]       t;
        logic [RECIP_W-1:0]          recip;
    } t_cfg;

    // pixel coordinate bits actually used
    function automatic int coord_w(input int cb);
        return (cb < COL_W) ? cb : COL_W;
    endfunction

    // width of a*u + b*v + c, exact
    function automatic int sum_w(input int cb);
        return COEF_W + coord_w(cb) + 2;
    endfunction

    // queue entry: {rgb, s2, s1, s0, depth}
    function automatic int entry_w(input int cb);
        return DQ_W + 3 * sum_w(cb) + 3 * COLOR_W;
    endfunction

endpackage

[hw/rtl/dpbp_pix_if.sv]
// ============================================================================
// dpbp_pix_if: pixel channel
// Valid/ready channel carrying one depth pixel per transaction.
// ============================================================================
interface dpbp_pix_if import dpbp_pkg::*; ();
    logic valid;
    logic ready;
    t_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/dpbp_pnt_if.sv]
// ============================================================================
// dpbp_pnt_if: point channel
// Valid/ready channel carrying one colored 3D point per transaction.
// ============================================================================
interface dpbp_pnt_if import dpbp_pkg::*; ();
    logic valid;
    logic ready;
    t_pnt data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/dpbp_front.sv]
// ============================================================================
// dpbp_front: pixel intake and classification
// Scales raw depth, forms per-axis coefficient sums, drops empty pixels.
// ============================================================================
module dpbp_front import dpbp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dpbp_pix_if.sink                         i_pix,
    input  t_cfg                             i_cfg,
    input  logic                             i_full,
    output logic                             o_push,
    output logic [entry_w(COORD_BITS)-1:0]   o_entry
);

    localparam int UW      = coord_w(COORD_BITS);
    localparam int PW      = COEF_W + UW + 1;
    localparam int SW      = sum_w(COORD_BITS);
    localparam int ENTRY_W = entry_w(COORD_BITS);
    localparam int DPROD_W = DEPTH_W + RECIP_W;

    logic                     adv;
    logic                     r_v1;
    logic                     r_v2;
    logic [DPROD_W-1:0]       r_dprod;
    logic signed [PW-1:0]     r_pu [3];
    logic signed [PW-1:0]     r_pv [3];
    logic [3*COLOR_W-1:0]     r_rgb1;
    logic [3*COLOR_W-1:0]     r_rgb2;
    logic [DQ_W-1:0]          r_d2;
    logic [DQ_W-1:0]          n_d2;
    logic signed [SW-1:0]     r_s [3];
    logic signed [UW:0]       u_s;
    logic signed [UW:0]       v_s;

    // whole front stalls while the queue is full
    assign adv         = !i_full;
    assign i_pix.ready = adv;

    assign u_s  = $signed({1'b0, i_pix.data.col[UW-1:0]});
    assign v_s  = $signed({1'b0, i_pix.data.row[UW-1:0]});
    assign n_d2 = r_dprod[DPROD_W-1 -: DQ_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_pix.valid && (i_pix.data.depth_raw != '0);
            r_v2 <= r_v1 && (n_d2 != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dprod <= DPROD_W'(i_pix.data.depth_raw) * DPROD_W'(i_cfg.recip);
            r_rgb1  <= {i_pix.data.red_in, i_pix.data.green_in, i_pix.data.blue_in};
            for (int k = 0; k < 3; k++) begin
                r_pu[k] <= $signed(i_cfg.a[k][0]) * u_s;
                r_pv[k] <= $signed(i_cfg.a[k][1]) * v_s;
            end
            r_d2   <= n_d2;
            r_rgb2 <= r_rgb1;
            for (int k = 0; k < 3; k++) begin
                r_s[k] <= SW'(r_pu[k]) + SW'(r_pv[k]) + SW'($signed(i_cfg.a[k][2]));
            end
        end
    end

    assign o_push  = r_v2 && adv;
    assign o_entry = ENTRY_W'({r_rgb2, r_s[2], r_s[1], r_s[0], r_d2});

`ifndef ASSERT_OFF
    a_push_nonzero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_entry[DQ_W-1:0] != '0))
        else $error("front pushed a point with zero depth");
`endif

endmodule

[hw/rtl/dpbp_queue.sv]
// ============================================================================
// dpbp_queue: decoupling queue
// Small show-ahead FIFO between the front and back pipelines.
// ============================================================================
module dpbp_queue import dpbp_pkg::*; #(
    parameter int WIDTH = entry_w(COORD_BITS_DEF),
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;

    assign n_wr  = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd  = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue write while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

[hw/rtl/dpbp_back.sv]
// ============================================================================
// dpbp_back: point arithmetic pipeline
// Sign-magnitude depth scaling, truncation, translation and saturation.
// ============================================================================
module dpbp_back import dpbp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  logic [entry_w(COORD_BITS)-1:0] i_entry,
    output logic                           o_pop,
    input  t_cfg                           i_cfg,
    dpbp_pnt_if.source                     o_pnt
);

    localparam int SW      = sum_w(COORD_BITS);
    localparam int ENTRY_W = entry_w(COORD_BITS);
    localparam int HI_W    = SW - 32;
    localparam int LO_W    = 64;
    localparam int QW      = SW + 4;
    localparam int RW      = QW + 2;
    localparam int RGB_W   = 3 * COLOR_W;

    logic                 adv;
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    logic                 r_v4;
    logic [DQ_W-1:0]      e_d;
    logic signed [SW-1:0] e_s [3];
    logic [RGB_W-1:0]     e_rgb;
    logic [SW-1:0]        n_mag [3];
    logic [SW-1:0]        r_mag [3];
    logic [2:0]           r_neg1;
    logic [2:0]           r_neg2;
    logic [2:0]           r_neg3;
    logic [DQ_W-1:0]      r_d1;
    logic [LO_W-1:0]      r_lo [3];
    logic [SW-1:0]        r_hi [3];
    logic [QW-1:0]        r_q [3];
    logic [RGB_W-1:0]     r_rgb1;
    logic [RGB_W-1:0]     r_rgb2;
    logic [RGB_W-1:0]     r_rgb3;
    logic signed [RW-1:0] n_sum [3];
    t_pnt                 r_pnt;

    function automatic logic [PNT_W-1:0] sat(input logic signed [RW-1:0] v);
        logic [PNT_W-1:0] res;
        if (!v[RW-1] && (|v[RW-2:PNT_W-1])) begin
            res = {1'b0, {(PNT_W-1){1'b1}}};
        end else if (v[RW-1] && !(&v[RW-2:PNT_W-1])) begin
            res = {1'b1, {(PNT_W-1){1'b0}}};
        end else begin
            res = v[PNT_W-1:0];
        end
        return res;
    endfunction

    // stall-all pipeline, output register is the last stage
    assign adv   = !r_v4 || o_pnt.ready;
    assign o_pop = adv && !i_empty;

    always_comb begin
        e_d   = i_entry[DQ_W-1:0];
        e_rgb = i_entry[ENTRY_W-1 -: RGB_W];
        for (int k = 0; k < 3; k++) begin
            e_s[k]   = $signed(i_entry[DQ_W + k*SW +: SW]);
            n_mag[k] = e_s[k][SW-1] ? (~e_s[k] + 1'b1) : e_s[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_neg3[k]) begin
                n_sum[k] = RW'($signed(i_cfg.t[k])) - $signed({2'b00, r_q[k]});
            end else begin
                n_sum[k] = RW'($signed(i_cfg.t[k])) + $signed({2'b00, r_q[k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // magnitude and sign
            r_d1   <= e_d;
            r_rgb1 <= e_rgb;
            for (int k = 0; k < 3; k++) begin
                r_neg1[k] <= e_s[k][SW-1];
                r_mag[k]  <= n_mag[k];
            end
            // split products, Q.44
            r_neg2 <= r_neg1;
            r_rgb2 <= r_rgb1;
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= LO_W'(r_mag[k][31:0]) * LO_W'(r_d1);
                r_hi[k] <= SW'(r_mag[k][SW-1:32]) * SW'(r_d1);
            end
            // truncate to Q.16
            r_neg3 <= r_neg2;
            r_rgb3 <= r_rgb2;
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= (QW'(r_hi[k]) << 4) + QW'(r_lo[k][LO_W-1:28]);
            end
            // translate and saturate
            r_pnt.point_x   <= sat(n_sum[0]);
            r_pnt.point_y   <= sat(n_sum[1]);
            r_pnt.point_z   <= sat(n_sum[2]);
            r_pnt.red_out   <= r_rgb3[RGB_W-1 -: COLOR_W];
            r_pnt.green_out <= r_rgb3[COLOR_W +: COLOR_W];
            r_pnt.blue_out  <= r_rgb3[COLOR_W-1:0];
        end
    end

    assign o_pnt.valid = r_v4;
    assign o_pnt.data  = r_pnt;

    // HI_W documents the upper partial-product operand width
    if (HI_W < 1) begin : g_bad_width
        $error("coordinate width too small for split multiply");
    end

endmodule

[hw/rtl/depth_pixel_back_projection_top.sv]
// ============================================================================
// depth_pixel_back_projection_top: depth pixel to colored 3D point
// Config register file, front classifier, decoupling queue, back arithmetic.
// ============================================================================
// Usage:
//   i_pix  : one depth pixel per transaction (col, row, depth_raw, BGR color).
//   o_pnt  : one point per transaction (x, y, z signed Q16.16, RGB color).
//   i_cfg_*: write port, one 64-bit register per write, index 0..6; writes to
//            index 7 are ignored. Write only while the block is idle.
//   Pixels with zero raw depth, or whose scaled depth truncates to zero,
//   produce no transaction on o_pnt.
// Throughput: one pixel per clock, sustained, as long as o_pnt.ready is high.
// Path: a pixel passes two front stages, one queue write and four back
//   stages incl. output reg before its point appears on o_pnt.
// Stall: back-pressure on o_pnt freezes the back pipeline; the front keeps
//   taking pixels until the queue is full, then drops i_pix.ready. The
//   queue full flag is registered, so i_pix.ready has no path from o_pnt.
// Reset: synchronous, active low. Clears all pipeline valids and the queue;
//   config registers return to zero, depth reciprocal to 1/256.
// ============================================================================
module depth_pixel_back_projection_top import dpbp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int Q_DEPTH    = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dpbp_pix_if.sink              i_pix,
    dpbp_pnt_if.source            o_pnt,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ENTRY_W = entry_w(COORD_BITS);

    t_cfg               r_cfg;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;

    // config register file; matrix halves land in their a[row][col] slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.a     <= '0;
            r_cfg.t     <= '0;
            r_cfg.recip <= RECIP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW0: begin
                    r_cfg.a[0][0] <= i_cfg_data[31:0];
                    r_cfg.a[0][1] <= i_cfg_data[63:32];
                end
                CFG_ROW1: begin
                    r_cfg.a[1][0] <= i_cfg_data[31:0];
                    r_cfg.a[1][1] <= i_cfg_data[63:32];
                end
                CFG_ROW2: begin
                    r_cfg.a[2][0] <= i_cfg_data[31:0];
                    r_cfg.a[2][1] <= i_cfg_data[63:32];
                end
                CFG_COL2: begin
                    r_cfg.a[0][2] <= i_cfg_data[31:0];
                    r_cfg.a[1][2] <= i_cfg_data[63:32];
                end
                CFG_COL2_TX: begin
                    r_cfg.a[2][2] <= i_cfg_data[31:0];
                    r_cfg.t[0]    <= i_cfg_data[63:32];
                end
                CFG_TRANS_YZ: begin
                    r_cfg.t[1] <= i_cfg_data[31:0];
                    r_cfg.t[2] <= i_cfg_data[63:32];
                end
                CFG_RECIP: begin
                    r_cfg.recip <= i_cfg_data[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    // front: depth scaling, coefficient sums, empty-pixel filter
    dpbp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (q_wdata)
    );

    // lets the front run on while the output is stalled
    dpbp_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // back: depth multiply, truncation toward zero, translate, saturate
    dpbp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_entry (q_rdata),
        .o_pop   (q_pop),
        .i_cfg   (r_cfg),
        .o_pnt   (o_pnt)
    );

endmodule

[tb/tb_top.sv]
// ============================================================================
// tb_top: depth pixel back-projection testbench
// Streams depth pixels through the block under several calibration settings,
// predicts each colored point from a local copy of the calibration registers
// and compares every point transaction field by field in arrival order.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dpbp_pkg::*;

    // ------------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------------
    localparam int COORD_BITS      = COORD_BITS_DEF;
    localparam longint COORD_MASK  = (longint'(1) << COORD_BITS) - 1;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int RANDOM_PHASES   = 15;
    localparam int HOLD_CYCLES     = 300;   // long back-pressure stretch
    localparam int SETTLE_CYCLES   = 12;    // drain time for pixels that give no point
    localparam int STALL_LIMIT     = 4000;  // cycles without any transaction

    localparam longint PNT_MAX = 64'sd2147483647;
    localparam longint PNT_MIN = -64'sd2147483648;

    // index past the register list; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    // flavors of random calibration
    typedef enum int {
        CAL_CAMERA,     // plausible intrinsics and rotation, no saturation
        CAL_SCALED,     // random magnitudes, tiny reciprocals included
        CAL_WILD        // every bit random, mostly saturating
    } t_cal_kind;

    // ------------------------------------------------------------------------
    // Clock, reset, channels, config port
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    dpbp_pix_if pix_if ();
    dpbp_pnt_if pnt_if ();

    depth_pixel_back_projection_top #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix_if),
        .o_pnt      (pnt_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] calib_regs [0:6];   // shadow of the register file
    t_pix  pixel_stream [$];                   // pixels waiting to be driven
    t_pnt  predicted_points [$];               // points owed by the block
    int    queued_pixels   = 0;
    int    accepted_pixels = 0;
    int    error_count     = 0;
    int    send_idle_pct   = 0;
    int    recv_idle_pct   = 0;
    bit    pix_taken       = 1'b0;  // pixel transaction at the last rising edge
    bit    hold_off_req    = 1'b0;  // ask the receiver for a long stall
    int    hold_left       = 0;
    int    quiet_cycles    = 0;

    // ------------------------------------------------------------------------
    // Point predictor
    // ------------------------------------------------------------------------
    function automatic longint as_signed32(input logic [31:0] w);
        return longint'($signed(w));
    endfunction

    // Returns 1 and the point when the pixel yields one. Per axis:
    // s = a0*u + a1*v + a2 (Q.28), s*d (Q.44) truncated toward zero to Q.16,
    // plus the translation, clamped to 32 bits.
    function automatic bit project_pixel(input t_pix px, output t_pnt pt);
        logic [63:0]  depth_q;
        longint       a_m [3][3];
        longint       t_v [3];
        logic [31:0]  axis [3];
        longint       u, v, s, r, acc;
        logic [63:0]  mag;
        logic [127:0] prod;
        bit           neg;

        pt = '0;
        if (px.depth_raw == '0) return 1'b0;
        depth_q = (64'(px.depth_raw) * 64'(calib_regs[CFG_RECIP][31:0])) >> 16;
        if (depth_q == '0) return 1'b0;

        a_m[0][0] = as_signed32(calib_regs[CFG_ROW0][31:0]);
        a_m[0][1] = as_signed32(calib_regs[CFG_ROW0][63:32]);
        a_m[0][2] = as_signed32(calib_regs[CFG_COL2][31:0]);
        a_m[1][0] = as_signed32(calib_regs[CFG_ROW1][31:0]);
        a_m[1][1] = as_signed32(calib_regs[CFG_ROW1][63:32]);
        a_m[1][2] = as_signed32(calib_regs[CFG_COL2][63:32]);
        a_m[2][0] = as_signed32(calib_regs[CFG_ROW2][31:0]);
        a_m[2][1] = as_signed32(calib_regs[CFG_ROW2][63:32]);
        a_m[2][2] = as_signed32(calib_regs[CFG_COL2_TX][31:0]);
        t_v[0]    = as_signed32(calib_regs[CFG_COL2_TX][63:32]);
        t_v[1]    = as_signed32(calib_regs[CFG_TRANS_YZ][31:0]);
        t_v[2]    = as_signed32(calib_regs[CFG_TRANS_YZ][63:32]);

        u = longint'(px.col) & COORD_MASK;
        v = longint'(px.row) & COORD_MASK;
        for (int k = 0; k < 3; k++) begin
            s    = a_m[k][0] * u + a_m[k][1] * v + a_m[k][2];
            neg  = (s < 0);
            mag  = neg ? 64'(-s) : 64'(s);
            prod = 128'(mag) * 128'(depth_q);
            r    = longint'(prod[91:28]);
            acc  = (neg ? -r : r) + t_v[k];
            if (acc > PNT_MAX)      axis[k] = 32'h7FFF_FFFF;
            else if (acc < PNT_MIN) axis[k] = 32'h8000_0000;
            else                    axis[k] = acc[31:0];
        end
        pt.point_x   = axis[0];
        pt.point_y   = axis[1];
        pt.point_z   = axis[2];
        pt.red_out   = px.red_in;
        pt.green_out = px.green_in;
        pt.blue_out  = px.blue_in;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // One register write; the shadow follows the block's own masking rules.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] word);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= word;
        if (idx <= CFG_RECIP)
            calib_regs[idx] = (idx == CFG_RECIP) ? {32'h0, word[31:0]} : word;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // t[0..2] = tx, ty, tz; recip_hi lands in the unused upper half
    task automatic apply_calib(input t_cfg c, input logic [31:0] recip_hi);
        write_reg(CFG_ROW0,     {c.a[0][1], c.a[0][0]});
        write_reg(CFG_ROW1,     {c.a[1][1], c.a[1][0]});
        write_reg(CFG_ROW2,     {c.a[2][1], c.a[2][0]});
        write_reg(CFG_COL2,     {c.a[1][2], c.a[0][2]});
        write_reg(CFG_COL2_TX,  {c.t[0], c.a[2][2]});
        write_reg(CFG_TRANS_YZ, {c.t[2], c.t[1]});
        write_reg(CFG_RECIP,    {recip_hi, c.recip});
    endtask

    task automatic queue_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                               input logic [DEPTH_W-1:0] raw, input logic [COLOR_W-1:0] b,
                               input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r);
        t_pix px;
        px.col       = col;
        px.row       = row;
        px.depth_raw = raw;
        px.blue_in   = b;
        px.green_in  = g;
        px.red_in    = r;
        pixel_stream = {pixel_stream, px};
        queued_pixels++;
    endtask

    // Block is idle once every pixel is in and every point is out; pixels
    // that give no point may still be in the pipe, hence the settle time.
    task automatic wait_idle();
        while (accepted_pixels != queued_pixels || predicted_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] coef_noise(input int shift);
        return 32'($signed($urandom) >>> shift);
    endfunction

    function automatic t_cfg random_calib(input t_cal_kind kind);
        t_cfg        c;
        int unsigned fx, fy, cx, cy;

        fx = $urandom_range(300, 1500);
        fy = $urandom_range(300, 1500);
        cx = $urandom_range(0, 2 * fx);
        cy = $urandom_range(0, 2 * fy);
        case (kind)
            CAL_CAMERA: begin
                // folded R * K^-1 with a slightly perturbed rotation
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) c.a[i][j] = coef_noise(14);
                    c.t[i] = coef_noise(10);
                end
                c.a[0][0] = c.a[0][0] + 32'((longint'(1) << 28) / fx);
                c.a[1][1] = c.a[1][1] + 32'((longint'(1) << 28) / fy);
                c.a[0][2] = c.a[0][2] - 32'((longint'(cx) << 28) / fx);
                c.a[1][2] = c.a[1][2] - 32'((longint'(cy) << 28) / fy);
                c.a[2][2] = c.a[2][2] + 32'h1000_0000;
                c.recip   = 32'($urandom_range(32'h0004_0000, 32'h0400_0000));
            end
            CAL_SCALED: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) c.a[i][j] = coef_noise($urandom_range(0, 20));
                    c.t[i] = coef_noise($urandom_range(0, 16));
                end
                c.recip = 32'($urandom >> $urandom_range(0, 31));
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) c.a[i][j] = 32'($urandom);
                    c.t[i] = 32'($urandom);
                end
                c.recip = 32'($urandom);
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Pixel driver: a pixel stays on the channel until its transaction
    // completes; a new one goes out unless the sender idles this cycle.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || pix_taken) begin
            if (pixel_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                pix_if.data  <= pixel_stream.pop_front();
                pix_if.valid <= 1'b1;
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
        pix_taken = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Point receiver: random stalls, plus one long hold-off on request so the
    // internal queue fills up and the block drops its pixel ready.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_off_req) begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pnt_if.ready <= 1'b0;
        end else begin
            pnt_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every pixel transaction, checks every point
    // transaction against the oldest prediction.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk) begin : monitor
        t_pnt want;
        t_pnt got;

        if (rst_n) begin
            if (pix_if.valid && pix_if.ready) begin
                pix_taken = 1'b1;
                accepted_pixels++;
                if (project_pixel(pix_if.data, want))
                    predicted_points = {predicted_points, want};
            end
            if (pnt_if.valid && pnt_if.ready) begin
                got = pnt_if.data;
                if (predicted_points.size() == 0) begin
                    $display("%0t: unexpected point x=%0d y=%0d z=%0d rgb=%0d,%0d,%0d",
                             $time, got.point_x, got.point_y, got.point_z,
                             got.red_out, got.green_out, got.blue_out);
                    error_count++;
                end else begin
                    want = predicted_points.pop_front();
                    check_field("point_x",   want.point_x,   got.point_x);
                    check_field("point_y",   want.point_y,   got.point_y);
                    check_field("point_z",   want.point_z,   got.point_z);
                    check_field("red_out",   want.red_out,   got.red_out);
                    check_field("green_out", want.green_out, got.green_out);
                    check_field("blue_out",  want.blue_out,  got.blue_out);
                end
            end
        end
    end

    // Watchdog: a lost point or a hung channel shows up as a long silence.
    always @(posedge clk) begin
        if ((pix_if.valid && pix_if.ready) || (pnt_if.valid && pnt_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d points outstanding",
                     $time, quiet_cycles, predicted_points.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        t_cfg             lab_cal;
        t_cfg             c;
        logic [COL_W-1:0] col, row, scan_col, scan_row;
        logic [DEPTH_W-1:0] raw;

        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        pnt_if.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        for (int i = 0; i < 7; i++) calib_regs[i] = '0;
        calib_regs[CFG_RECIP] = {32'h0, RECIP_RESET};

        send_idle_pct = 22;
        recv_idle_pct = 81;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // --- reset calibration: zero matrix and offset, depth scale 1/256 ---
        queue_pixel(12'd4095, 12'd4095, 16'd0, 8'hFF, 8'hFF, 8'hFF);   // no depth
        queue_pixel(12'd0, 12'd0, 16'd1, 8'h12, 8'h34, 8'h56);
        wait_idle();

        // --- 640x480-style camera, millimeter depth, small pose offset ---
        lab_cal.a[0][0] = 32'sd511305;
        lab_cal.a[0][1] = 32'sd2000;
        lab_cal.a[0][2] = -32'sd163362000;
        lab_cal.a[1][0] = -32'sd1500;
        lab_cal.a[1][1] = 32'sd511305;
        lab_cal.a[1][2] = -32'sd122458000;
        lab_cal.a[2][0] = 32'sd700;
        lab_cal.a[2][1] = -32'sd900;
        lab_cal.a[2][2] = 32'sh1000_0000;
        lab_cal.t[0]    = 32'sd6554;
        lab_cal.t[1]    = -32'sd13107;
        lab_cal.t[2]    = 32'sd65536;
        lab_cal.recip   = 32'd4294967;
        apply_calib(lab_cal, 32'h0);
        write_reg(CFG_IDX_UNUSED, '1);   // must leave every register alone
        queue_pixel(12'd0,    12'd0,    16'd1,     8'h00, 8'h00, 8'h00);
        queue_pixel(12'd4095, 12'd0,    16'd65535, 8'hFF, 8'h00, 8'h00);
        queue_pixel(12'd0,    12'd4095, 16'd65535, 8'h00, 8'hFF, 8'h00);
        queue_pixel(12'd4095, 12'd4095, 16'd65535, 8'h00, 8'h00, 8'hFF);
        queue_pixel(12'd320,  12'd240,  16'd1000,  8'h80, 8'h40, 8'h20);
        queue_pixel(12'd4095, 12'd4095, 16'd1,     8'hFF, 8'hFF, 8'hFF);
        queue_pixel(12'd2048, 12'd1024, 16'd0,     8'h01, 8'h02, 8'h03);
        queue_pixel(12'd100,  12'd3000, 16'd40000, 8'hAA, 8'h55, 8'hCC);
        wait_idle();

        // --- largest positive everything: all axes clamp high ---
        c.a     = {9{32'h7FFF_FFFF}};
        c.t     = {3{32'h7FFF_FFFF}};
        c.recip = '1;
        apply_calib(c, 32'hFFFF_FFFF);
        queue_pixel(12'd4095, 12'd4095, 16'd65535, 8'h0F, 8'hF0, 8'h3C);
        queue_pixel(12'd0,    12'd0,    16'd1,     8'hC3, 8'h5A, 8'hA5);
        wait_idle();

        // --- most negative coefficients and offset: all axes clamp low ---
        c.a = {9{32'h8000_0000}};
        c.t = {3{32'h8000_0000}};
        apply_calib(c, 32'h0);
        queue_pixel(12'd4095, 12'd4095, 16'd65535, 8'h11, 8'h22, 8'h33);
        queue_pixel(12'd0,    12'd0,    16'd1,     8'h44, 8'h55, 8'h66);
        wait_idle();

        // --- all registers zero: zero reciprocal, so no points at all ---
        apply_calib('0, 32'h0);
        queue_pixel(12'd1,    12'd1, 16'd65535, 8'h77, 8'h88, 8'h99);
        queue_pixel(12'd4095, 12'd0, 16'd1,     8'hFE, 8'h01, 8'h7F);
        wait_idle();

        // --- depth truncates to zero, then the smallest nonzero depth ---
        c       = lab_cal;
        c.recip = 32'd1;
        apply_calib(c, 32'h0);
        queue_pixel(12'd10, 12'd10, 16'd65535, 8'h10, 8'h20, 8'h30);
        wait_idle();
        write_reg(CFG_RECIP, 64'd65536);
        queue_pixel(12'd5, 12'd7, 16'd1, 8'h31, 8'h32, 8'h33);
        wait_idle();

        // --- random phases, each under its own calibration ---
        scan_col = 12'($urandom);
        scan_row = 12'($urandom);
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < RANDOM_PHASES / 3) begin
                send_idle_pct = 22;
                recv_idle_pct = 81;
            end else if (phase < 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 81;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase % 3 == 0)
                apply_calib(random_calib(CAL_CAMERA), 32'($urandom));
            else if (phase % 3 == 1)
                apply_calib(random_calib(CAL_SCALED), 32'($urandom));
            else
                apply_calib(random_calib(CAL_WILD), 32'($urandom));

            // full-rate sender against a stalled receiver
            if (phase == 2 * RANDOM_PHASES / 3)
                hold_off_req = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(9))
                    0:       raw = '0;
                    1:       raw = 16'($urandom_range(1, 15));
                    2:       raw = '1;
                    default: raw = 16'($urandom);
                endcase
                case ($urandom_range(4))
                    0: begin    // image corners
                        col = $urandom_range(1) ? '1 : '0;
                        row = $urandom_range(1) ? '1 : '0;
                    end
                    1, 2: begin // raster scan
                        col      = scan_col;
                        row      = scan_row;
                        scan_col = scan_col + 1'b1;
                        if (scan_col == '0) scan_row = scan_row + 1'b1;
                    end
                    default: begin
                        col = 12'($urandom);
                        row = 12'($urandom);
                    end
                endcase
                queue_pixel(col, row, raw, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            wait_idle();
        end

        if (error_count == 0 && predicted_points.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
